FILE: hdl/fcac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcac_pkg
// shared types and constants of the sync / type / length frame checker
// ----------------------------------------------------------------------------
package fcac_pkg;

	localparam int COUNT_WIDTH_DEF = 15;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 16;
	localparam int STATUS_W        = 3;
	localparam int M_TDATA_W       = 24;

	// frame phase, in order of arrival
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_TYPE    = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CHECK   = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_SYNC1  = 3'd2,
		ST_SYNC2  = 3'd3,
		ST_LENGTH = 3'd4,
		ST_CHECK  = 3'd5
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic {
		CFG_FIRST_SYNC  = 1'b0,
		CFG_SECOND_SYNC = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} in_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload;
		logic [BYTE_W-1:0] frame_type;
		status_t           status;
	} result_t;

endpackage

FILE: hdl/frame_checker_additive_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker_additive_checksum
// checks a sync / type / length / payload / 16-bit sum frame in a byte stream
// ----------------------------------------------------------------------------
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tdata: data_byte; tlast: end_of_buffer
// m_*       out  m_tvalid/m_tready  tdata: payload_byte, frame_type, status;
//                                   tuser: result_kind
// cfg_*     in   cfg_we             cfg_index 0 first sync, 1 second sync
//
// one byte per cycle sustained while m_tready stays high; a byte is held in the
// input register, and the parser updates as it moves into the result register,
// which raises m_tvalid when the byte gives a payload byte or a verdict
// reset (arst_n low) clears the parser state, both sync values and valids
// m_tready low holds the result; the input register still takes one more byte
// ----------------------------------------------------------------------------
module frame_checker_additive_checksum #(
	parameter int COUNT_WIDTH = fcac_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// receive byte stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fcac_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
	input  logic                           s_tlast,   // end_of_buffer
	// results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fcac_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte,
	                                                  // [15:8] frame_type,
	                                                  // [18:16] status, rest zero
	output logic                           m_tuser,   // result_kind
	// configuration writes
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fcac_pkg::BYTE_W-1:0]    cfg_data
);

	logic [fcac_pkg::BYTE_W-1:0] first_sync_q;
	logic [fcac_pkg::BYTE_W-1:0] second_sync_q;
	fcac_pkg::in_item_t          in_item;
	fcac_pkg::in_item_t          item_s1;
	logic                        item_valid_s1;
	logic                        advance;
	logic                        res_valid;
	fcac_pkg::result_t           res;
	fcac_pkg::result_t           out_q;

	// sync value registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= '0;
			second_sync_q <= '0;
		end else if (cfg_we) begin
			unique case (fcac_pkg::cfg_index_t'(cfg_index))
				fcac_pkg::CFG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				fcac_pkg::CFG_SECOND_SYNC: second_sync_q <= cfg_data;
			endcase
		end
	end

	assign in_item.data = s_tdata;
	assign in_item.last = s_tlast;

	fcac_input_stage u_input (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	// parser state advances only when the byte moves on
	fcac_frame_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item_s1     (item_s1),
		.first_sync  (first_sync_q),
		.second_sync (second_sync_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	fcac_output_reg u_output (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.res_valid     (res_valid),
		.res           (res),
		.advance       (advance),
		.out_valid_q   (m_tvalid),
		.out_ready     (m_tready),
		.out_q         (out_q)
	);

	// pack result fields, low field first, pad to whole bytes
	assign m_tdata = {5'b00000, out_q.status, out_q.frame_type, out_q.payload};
	assign m_tuser = out_q.kind;

	// a verdict never carries a payload byte or an out-of-range status
	a_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00 &&
			(m_tdata[18:16] == fcac_pkg::ST_OK || m_tdata[18:16] == fcac_pkg::ST_SHORT ||
			 m_tdata[18:16] == fcac_pkg::ST_SYNC1 || m_tdata[18:16] == fcac_pkg::ST_SYNC2 ||
			 m_tdata[18:16] == fcac_pkg::ST_LENGTH || m_tdata[18:16] == fcac_pkg::ST_CHECK))
		else $error("malformed verdict");

	// tentative payload bytes always report ok
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[18:16] == fcac_pkg::ST_OK)
		else $error("payload byte with nonzero status");

endmodule

FILE: hdl/fcac_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcac_input_stage
// input register that holds one received byte until the checker takes it
// ----------------------------------------------------------------------------
module fcac_input_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fcac_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              item_valid_s1,
	output fcac_pkg::in_item_t item_s1
);

	assign in_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: hdl/fcac_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcac_frame_fsm
// frame parser: header checks, payload sum, checksum compare and verdict
// ----------------------------------------------------------------------------
module fcac_frame_fsm #(
	parameter int COUNT_WIDTH = fcac_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  fcac_pkg::in_item_t          item_s1,
	input  logic [fcac_pkg::BYTE_W-1:0] first_sync,
	input  logic [fcac_pkg::BYTE_W-1:0] second_sync,
	output logic                        res_valid,
	output fcac_pkg::result_t           res
);

	fcac_pkg::phase_t               phase_q, phase_d;
	logic [fcac_pkg::LEN_W-1:0]     len_q, len_d;
	logic [COUNT_WIDTH-1:0]         cnt_q, cnt_d, cnt_inc;
	logic [fcac_pkg::LEN_W-1:0]     sum_q, sum_d;
	logic [fcac_pkg::LEN_W-1:0]     chk_q, chk_d;
	logic [fcac_pkg::BYTE_W-1:0]    type_q, type_d;
	fcac_pkg::status_t              err_q, err_d;
	logic                           emit_pl;
	logic [fcac_pkg::BYTE_W-1:0]    b;

	assign b       = item_s1.data;
	assign cnt_inc = cnt_q + COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fcac_pkg::PH_SYNC1;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
			type_q  <= '0;
			err_q   <= fcac_pkg::ST_OK;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			chk_q   <= chk_d;
			type_q  <= type_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		chk_d   = chk_q;
		type_d  = type_q;
		err_d   = err_q;
		emit_pl = 1'b0;
		unique case (phase_q)
			fcac_pkg::PH_SYNC1: begin
				if (b != first_sync && err_d == fcac_pkg::ST_OK) begin
					err_d = fcac_pkg::ST_SYNC1;
				end
				phase_d = fcac_pkg::PH_SYNC2;
			end
			fcac_pkg::PH_SYNC2: begin
				if (b != second_sync && err_d == fcac_pkg::ST_OK) begin
					err_d = fcac_pkg::ST_SYNC2;
				end
				phase_d = fcac_pkg::PH_TYPE;
			end
			fcac_pkg::PH_TYPE: begin
				type_d  = b;
				phase_d = fcac_pkg::PH_LEN_HI;
			end
			fcac_pkg::PH_LEN_HI: begin
				len_d   = {b, 8'h00};
				phase_d = fcac_pkg::PH_LEN_LO;
			end
			fcac_pkg::PH_LEN_LO: begin
				len_d = {len_q[15:8], b};
				// any length bit beyond the count range is rejected
				if ((len_d >> COUNT_WIDTH) != '0 && err_d == fcac_pkg::ST_OK) begin
					err_d = fcac_pkg::ST_LENGTH;
				end
				cnt_d = '0;
				if (err_d != fcac_pkg::ST_OK || len_d == '0) begin
					phase_d = fcac_pkg::PH_CHECK;
				end else begin
					phase_d = fcac_pkg::PH_PAYLOAD;
				end
			end
			fcac_pkg::PH_PAYLOAD: begin
				emit_pl = 1'b1;
				sum_d   = sum_q + fcac_pkg::LEN_W'(b);
				cnt_d   = cnt_inc;
				if (fcac_pkg::LEN_W'(cnt_inc) == len_q) begin
					cnt_d   = '0;
					phase_d = fcac_pkg::PH_CHECK;
				end
			end
			fcac_pkg::PH_CHECK: begin
				// count doubles as high/low byte marker here
				if (cnt_q == '0) begin
					chk_d = {b, 8'h00};
					cnt_d = COUNT_WIDTH'(1);
				end else begin
					chk_d = {chk_q[15:8], b};
					if (chk_d != sum_q && err_d == fcac_pkg::ST_OK) begin
						err_d = fcac_pkg::ST_CHECK;
					end
					phase_d = fcac_pkg::PH_DONE;
				end
			end
			fcac_pkg::PH_DONE: begin
				// trailing bytes ignored
			end
		endcase

		res_valid      = item_s1.last || emit_pl;
		res.frame_type = type_d;
		if (item_s1.last) begin
			res.kind    = fcac_pkg::KIND_VERDICT;
			res.payload = '0;
			res.status  = (phase_d == fcac_pkg::PH_DONE) ? err_d : fcac_pkg::ST_SHORT;
			phase_d     = fcac_pkg::PH_SYNC1;
			len_d       = '0;
			cnt_d       = '0;
			sum_d       = '0;
			chk_d       = '0;
			type_d      = '0;
			err_d       = fcac_pkg::ST_OK;
		end else begin
			res.kind    = fcac_pkg::KIND_PAYLOAD;
			res.payload = b;
			res.status  = fcac_pkg::ST_OK;
		end
	end

	// buffer end always leaves a clean parser
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last |=> phase_q == fcac_pkg::PH_SYNC1 &&
			err_q == fcac_pkg::ST_OK && sum_q == '0)
		else $error("parser not cleared after buffer end");

	// payload is only taken when the header was clean
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fcac_pkg::PH_PAYLOAD |-> err_q == fcac_pkg::ST_OK &&
			fcac_pkg::LEN_W'(cnt_q) < len_q)
		else $error("payload phase with header error or count overrun");

	// check phase count only marks the checksum byte position
	a_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fcac_pkg::PH_CHECK |-> cnt_q == '0 || cnt_q == COUNT_WIDTH'(1))
		else $error("bad checksum byte marker");

endmodule

FILE: hdl/fcac_output_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcac_output_reg
// result register that holds one result until the sink takes it
// ----------------------------------------------------------------------------
module fcac_output_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid_s1,
	input  logic              res_valid,
	input  fcac_pkg::result_t res,
	output logic              advance,
	output logic              out_valid_q,
	input  logic              out_ready,
	output fcac_pkg::result_t out_q
);

	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign advance   = item_valid_s1 && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sync / type / length / sum frame checker
// ----------------------------------------------------------------------------
// buffers of bytes are queued by the stimulus block and fed one per
// transaction by a clocked driver. Every accepted byte runs through a
// byte-level parser kept in the bench, which lines up the tentative payload
// bytes and the final verdict that the block should give. A clocked monitor
// pops those in order and compares kind, payload, type and status. Three
// phases run with different sync values and different stall patterns on
// each side. A short directed set comes first, then mostly well-formed
// frames with random content, mixed with damaged, cut-off and noisy buffers.
// ----------------------------------------------------------------------------
module testbench;
	import fcac_pkg::*;

	localparam int COUNT_W     = COUNT_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;
	localparam int SHOW_MAX    = 10;

	// clock, reset and block inputs, all known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_FIRST_SYNC;
	logic [BYTE_W-1:0]    cfg_data  = '0;

	// bytes waiting to be offered, and outputs the parser says must come
	in_item_t byte_stream[$];
	result_t  payload_and_verdicts[$];
	in_item_t next_byte;
	result_t  awaited;

	// stall rates in percent, changed per phase
	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int mismatches    = 0;
	int cycles        = 0;

	// bench copy of the sync registers
	logic [BYTE_W-1:0] sync_first_cfg  = '0;
	logic [BYTE_W-1:0] sync_second_cfg = '0;

	// bench copy of the parser state
	phase_t             st_phase;
	logic [LEN_W-1:0]   st_len;
	logic [COUNT_W-1:0] st_count;
	logic [LEN_W-1:0]   st_sum;
	logic [LEN_W-1:0]   st_rx_check;
	logic [BYTE_W-1:0]  st_type;
	status_t            st_err;

	frame_checker_additive_checksum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// back to the start of a buffer
	task automatic clear_frame_state();
		st_phase    = PH_SYNC1;
		st_len      = '0;
		st_count    = '0;
		st_sum      = '0;
		st_rx_check = '0;
		st_type     = '0;
		st_err      = ST_OK;
	endtask

	// only the first header or checksum problem is reported
	task automatic keep_first_error(input status_t code);
		if (st_err == ST_OK)
			st_err = code;
	endtask

	// advance the parser by one accepted byte and line up what it gives
	task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
		result_t r;
		logic    pass_on;
		pass_on = 1'b0;
		case (st_phase)
			PH_SYNC1: begin
				if (b != sync_first_cfg)
					keep_first_error(ST_SYNC1);
				st_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b != sync_second_cfg)
					keep_first_error(ST_SYNC2);
				st_phase = PH_TYPE;
			end
			PH_TYPE: begin
				st_type  = b;
				st_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				st_len   = {b, 8'h00};
				st_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				st_len = {st_len[15:8], b};
				// a length the payload counter cannot hold is refused
				if ((st_len >> COUNT_W) != 0)
					keep_first_error(ST_LENGTH);
				st_count = '0;
				// after a header error or a zero length the checksum is taken right away
				st_phase = (st_err != ST_OK || st_len == 0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				pass_on  = 1'b1;
				st_sum   = st_sum + LEN_W'(b);
				st_count = st_count + 1'b1;
				if (st_count == st_len) begin
					st_count = '0;
					st_phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (st_count == 0) begin
					st_rx_check = {b, 8'h00};
					st_count    = COUNT_W'(1);
				end else begin
					st_rx_check = {st_rx_check[15:8], b};
					if (st_rx_check != st_sum)
						keep_first_error(ST_CHECK);
					st_phase = PH_DONE;
				end
			end
			default: begin
				// trailing bytes after the checksum are dropped
			end
		endcase

		if (last) begin
			// the final byte gives only the verdict, even inside the payload
			r.kind       = KIND_VERDICT;
			r.payload    = '0;
			r.frame_type = st_type;
			r.status     = (st_phase == PH_DONE) ? st_err : ST_SHORT;
			payload_and_verdicts.push_back(r);
			clear_frame_state();
		end else if (pass_on) begin
			r.kind       = KIND_PAYLOAD;
			r.payload    = b;
			r.frame_type = st_type;
			r.status     = ST_OK;
			payload_and_verdicts.push_back(r);
		end
	endtask

	// count a mismatch and show the first few
	task automatic flag_mismatch(input string why, input result_t want);
		mismatches++;
		if (mismatches <= SHOW_MAX) begin
			$write("%s: expected kind %0d payload %02h type %02h status %0d, ",
				why, want.kind, want.payload, want.frame_type, want.status);
			$display("got kind %0d payload %02h type %02h status %0d",
				m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[18:16]);
		end
	endtask

	// both sync registers, one after the other, while the block is idle
	task automatic write_syncs(input logic [BYTE_W-1:0] first_val,
			input logic [BYTE_W-1:0] second_val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FIRST_SYNC;
		cfg_data  <= first_val;
		@(posedge clk);
		cfg_index <= CFG_SECOND_SYNC;
		cfg_data  <= second_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sync_first_cfg  = first_val;
		sync_second_cfg = second_val;
	endtask

	// one buffer: header, payload, checksum, trailing bytes, maybe cut short
	task automatic queue_buffer(input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] ftype, input logic [15:0] len, input int payload_n,
			input logic spoil_sum, input int trailing, input int cut_at);
		logic [7:0]  bytes[$];
		logic [7:0]  p;
		logic [15:0] sum;
		in_item_t    it;
		sum   = '0;
		bytes = {s1, s2, ftype, len[15:8], len[7:0]};
		for (int i = 0; i < payload_n; i++) begin
			p   = 8'($urandom);
			sum = sum + 16'(p);
			bytes.push_back(p);
		end
		if (spoil_sum)
			sum = sum ^ 16'($urandom_range(1, 65535));
		bytes.push_back(sum[15:8]);
		bytes.push_back(sum[7:0]);
		for (int i = 0; i < trailing; i++)
			bytes.push_back(8'($urandom));
		if (cut_at > 0 && cut_at < bytes.size())
			bytes = bytes[0:cut_at-1];
		foreach (bytes[i]) begin
			it.data = bytes[i];
			it.last = (i == bytes.size() - 1);
			byte_stream.push_back(it);
		end
	endtask

	// mostly good frames, the rest damaged in one way or another
	task automatic queue_random_buffer();
		int          pick;
		logic [15:0] len;
		logic [7:0]  s1;
		logic [7:0]  s2;
		pick = $urandom_range(99);
		len  = ($urandom_range(9) == 0) ? 16'($urandom_range(11, 48)) :
			16'($urandom_range(0, 10));
		s1   = sync_first_cfg;
		s2   = sync_second_cfg;
		if (pick < 60) begin
			queue_buffer(s1, s2, 8'($urandom), len, int'(len), 1'b0,
				($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0, 0);
		end else if (pick < 68) begin
			queue_buffer(s1, s2, 8'($urandom), len, int'(len), 1'b1,
				$urandom_range(0, 2), 0);
		end else if (pick < 74) begin
			// bad first sync, second one sometimes bad as well
			s1 = s1 ^ 8'($urandom_range(1, 255));
			if ($urandom_range(1))
				s2 = s2 ^ 8'($urandom_range(1, 255));
			queue_buffer(s1, s2, 8'($urandom), len, 0, 1'b0, $urandom_range(0, 2), 0);
		end else if (pick < 79) begin
			s2 = s2 ^ 8'($urandom_range(1, 255));
			queue_buffer(s1, s2, 8'($urandom), len, 0, 1'b0, $urandom_range(0, 2), 0);
		end else if (pick < 84) begin
			// length beyond the counter range
			len = {1'b1, 15'($urandom)};
			queue_buffer(s1, s2, 8'($urandom), len, 0, 1'b0, $urandom_range(0, 2), 0);
		end else if (pick < 92) begin
			// buffer ends somewhere before the checksum is complete
			queue_buffer(s1, s2, 8'($urandom), len, int'(len), 1'b0, 0,
				$urandom_range(1, 6 + len));
		end else begin
			// noise
			queue_buffer(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
				$urandom_range(0, 6), 1'b1, $urandom_range(0, 4), 0);
		end
	endtask

	// driver: offer the next byte when the slot is free, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// a transaction completes at this edge
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_byte = byte_stream.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_byte.data;
					s_tlast  <= next_byte.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction with the oldest one awaited
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (payload_and_verdicts.size() == 0) begin
					flag_mismatch("result with nothing awaited", '0);
				end else begin
					awaited = payload_and_verdicts.pop_front();
					if (m_tuser !== awaited.kind || m_tdata[7:0] !== awaited.payload ||
							m_tdata[15:8] !== awaited.frame_type ||
							m_tdata[18:16] !== awaited.status)
						flag_mismatch("result mismatch", awaited);
				end
			end
			m_tready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clear_frame_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 29;
					take_idle_pct = 67;
					write_syncs(8'h00, 8'hFF);
					// one-byte buffer, short
					queue_buffer(8'hFF, 8'h00, 8'h00, 16'h0000, 0, 1'b0, 0, 1);
					// zero length, checksum of zero, all-ones type
					queue_buffer(8'h00, 8'hFF, 8'hFF, 16'h0000, 0, 1'b0, 0, 0);
					// both syncs and length bad, first sync wins
					queue_buffer(8'hFF, 8'h00, 8'h00, 16'h8000, 0, 1'b0, 0, 0);
					// buffer ends on a payload byte
					queue_buffer(8'h00, 8'hFF, 8'h5A, 16'd2, 2, 1'b0, 0, 7);
				end
				1: begin
					send_idle_pct = 67;
					take_idle_pct = 29;
					write_syncs(8'hFF, 8'h00);
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
					write_syncs(8'($urandom), 8'($urandom));
				end
			endcase
			while (byte_stream.size() < ((ph == 0) ? 330 : 400))
				queue_random_buffer();
			// let everything drain before touching the sync registers again
			while (byte_stream.size() != 0 || s_tvalid || payload_and_verdicts.size() != 0)
				@(posedge clk);
			repeat (DRAIN_WAIT) @(posedge clk);
		end

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
